### sv/voxel_face_cull_mesher_defines.svh
// Assertion macros for the voxel face culling mesher.
`ifndef VOXEL_FACE_CULL_MESHER_DEFINES_SVH
`define VOXEL_FACE_CULL_MESHER_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define VFCM_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define VFCM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define VFCM_ASSERT_IMPL(label, ante, cons)
`define VFCM_ASSERT_NEXT(label, ante, cons)
`endif
`endif

### sv/vfcm_pkg.sv
// ---------------------------------------------------------------------------
// Voxel face culling mesher package
// Shared types, constants and corner tables.
// ---------------------------------------------------------------------------
package vfcm_pkg;

    localparam int SIDE = 32;
    localparam int CW = $clog2(SIDE);
    localparam int AW = 3 * CW;
    localparam int DEPTH = SIDE * SIDE * SIDE;
    localparam int QDEPTH = 2;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_MESH = 1'b1;

    typedef struct packed {
        logic        opcode;
        logic [4:0]  voxel_x;
        logic [4:0]  voxel_y;
        logic [4:0]  voxel_z;
        logic [23:0] voxel_value;
    } in_word_t;

    typedef struct packed {
        logic [5:0]  vertex_x;
        logic [5:0]  vertex_y;
        logic [5:0]  vertex_z;
        logic [23:0] vertex_color;
        logic [2:0]  face_id;
        logic        last;
    } out_word_t;

    // Classified command passed from the front to the back.
    typedef struct packed {
        logic [4:0] x;
        logic [4:0] y;
        logic [4:0] z;
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CENTRE,
        ST_PROBE,
        ST_DECIDE,
        ST_EMIT
    } back_state_t;

    // Corner offsets packed as {x,y,z}.
    function automatic logic [2:0] corner_off(input logic [2:0] c);
        logic [2:0] r;
        begin
            case (c)
                3'd0: r = 3'b001;
                3'd1: r = 3'b101;
                3'd2: r = 3'b111;
                3'd3: r = 3'b011;
                3'd4: r = 3'b000;
                3'd5: r = 3'b100;
                3'd6: r = 3'b110;
                default: r = 3'b010;
            endcase
            corner_off = r;
        end
    endfunction

    // Corner number for face f and triangle vertex v.
    function automatic logic [2:0] face_corner(input logic [2:0] f, input logic [2:0] v);
        logic [11:0] q;
        logic [1:0]  k;
        begin
            case (f)
                3'd0: q = {3'd0, 3'd3, 3'd7, 3'd4};
                3'd1: q = {3'd1, 3'd5, 3'd6, 3'd2};
                3'd2: q = {3'd0, 3'd4, 3'd5, 3'd1};
                3'd3: q = {3'd3, 3'd2, 3'd6, 3'd7};
                3'd4: q = {3'd7, 3'd6, 3'd5, 3'd4};
                default: q = {3'd0, 3'd1, 3'd2, 3'd3};
            endcase
            case (v)
                3'd0: k = 2'd0;
                3'd1: k = 2'd1;
                3'd2: k = 2'd2;
                3'd3: k = 2'd0;
                3'd4: k = 2'd2;
                default: k = 2'd3;
            endcase
            face_corner = q[(2'd3 - k) * 3 +: 3];
        end
    endfunction

endpackage

### sv/voxel_face_cull_mesher.sv
// With the back end idle, an accepted mesh word is queued, popped with a centre read, and
// its neighbours probed; faces that are not visible are skipped before its first vertex.
// One vertex per cycle while emitting, unless the receiver stalls; an empty voxel ends
// after its centre read, a hidden one after its probes; a write is taken only once the
// queue and the back end are idle. Reset: asynchronous active low; the store is then
// cleared by a pass over every address, while mesh words queue and writes are held off.
// ---------------------------------------------------------------------------
// Voxel face culling mesher
// Stores a voxel grid and emits the vertices of exposed faces of a voxel.
// ---------------------------------------------------------------------------
module voxel_face_cull_mesher (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  vfcm_pkg::in_word_t  in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output vfcm_pkg::out_word_t out_data
);
    import vfcm_pkg::*;

    logic          wr_en, push, pop, q_ne, q_full, busy;
    logic [AW-1:0] wr_addr;
    logic [23:0]   wr_data;
    cmd_t          push_cmd, head;

    vfcm_front u_front (
        .valid(in_valid), .stall(in_stall), .data(in_data),
        .q_full(q_full), .back_busy(busy || q_ne), .wr_en(wr_en), .wr_addr(wr_addr),
        .wr_data(wr_data), .push(push), .push_cmd(push_cmd)
    );

    vfcm_queue u_queue (
        .clk(clk), .rst_n(rst_n), .push(push), .push_cmd(push_cmd), .pop(pop),
        .not_empty(q_ne), .full(q_full), .head(head)
    );

    vfcm_back u_back (
        .clk(clk), .rst_n(rst_n), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
        .q_valid(q_ne), .q_head(head), .q_pop(pop), .busy(busy),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
    );

endmodule

### sv/vfcm_front.sv
// ---------------------------------------------------------------------------
// Front end
// Accepts input words, performs voxel writes and queues mesh commands.
// ---------------------------------------------------------------------------
module vfcm_front (
    input  logic               valid,
    output logic               stall,
    input  vfcm_pkg::in_word_t data,
    input  logic               q_full,
    input  logic               back_busy,
    output logic               wr_en,
    output logic [vfcm_pkg::AW-1:0] wr_addr,
    output logic [23:0]        wr_data,
    output logic               push,
    output vfcm_pkg::cmd_t     push_cmd
);
    import vfcm_pkg::*;

    logic in_range;
    logic acc;

    // Coordinates must fall inside the grid.
    assign in_range = (32'(data.voxel_x) < SIDE) && (32'(data.voxel_y) < SIDE)
                   && (32'(data.voxel_z) < SIDE);

    // Writes wait for the back to drain so reads see them in order.
    assign stall = (data.opcode == OP_MESH) ? q_full : (back_busy || q_full);
    assign acc = valid && !stall;

    assign wr_en = acc && (data.opcode == OP_WRITE) && in_range;
    assign wr_addr = {data.voxel_x[CW-1:0], data.voxel_y[CW-1:0], data.voxel_z[CW-1:0]};
    assign wr_data = data.voxel_value;
    assign push = acc && (data.opcode == OP_MESH) && in_range;
    assign push_cmd = '{x: data.voxel_x, y: data.voxel_y, z: data.voxel_z};

endmodule

### sv/vfcm_queue.sv
// ---------------------------------------------------------------------------
// Command queue
// Small FIFO between the front and the back end.
// ---------------------------------------------------------------------------
module vfcm_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  vfcm_pkg::cmd_t push_cmd,
    input  logic           pop,
    output logic           not_empty,
    output logic           full,
    output vfcm_pkg::cmd_t head
);
    import vfcm_pkg::*;

    cmd_t       slot_reg [QDEPTH];
    logic       wp_reg, wp_next, rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;

    assign not_empty = cnt_reg != 2'd0;
    assign full = cnt_reg == 2'(QDEPTH);
    assign head = slot_reg[rp_reg];

    // Pointer and count update.
    always_comb
    begin
        wp_next = push ? !wp_reg : wp_reg;
        rp_next = pop ? !rp_reg : rp_reg;
        cnt_next = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg <= wp_next;
            rp_reg <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    // Slot storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wp_reg] <= push_cmd;
        end
    end

endmodule

### sv/vfcm_back.sv
// ---------------------------------------------------------------------------
// Back end
// Owns the voxel store, probes neighbours and emits face vertices.
// ---------------------------------------------------------------------------
module vfcm_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    wr_en,
    input  logic [vfcm_pkg::AW-1:0] wr_addr,
    input  logic [23:0]             wr_data,
    input  logic                    q_valid,
    input  vfcm_pkg::cmd_t          q_head,
    output logic                    q_pop,
    output logic                    busy,
    output logic                    out_valid,
    input  logic                    out_stall,
    output vfcm_pkg::out_word_t     out_data
);
    import vfcm_pkg::*;
    `include "voxel_face_cull_mesher_defines.svh"

    logic [23:0]  mem [DEPTH];
    logic [23:0]  rd_reg;
    logic [AW-1:0] rd_addr;
    logic         rd_en;

    logic [AW:0]  clr_reg, clr_next;
    logic         clearing;
    back_state_t  st_reg, st_next;
    cmd_t         cmd_reg, cmd_next;
    logic [23:0]  col_reg, col_next;
    logic [2:0]   f_reg, f_next;
    logic [2:0]   v_reg, v_next;
    logic [5:0]   vis_reg, vis_next;
    logic         ov_reg, ov_next;
    out_word_t    od_reg, od_next;

    logic         nb_out, nb_solid_out;
    logic [CW-1:0] nx, ny, nz;
    logic [5:0]   rem_mask;
    logic [2:0]   nf;
    logic         has_next;
    logic [2:0]   co;

    assign clearing = !clr_reg[AW];

    // Memory: clear sweep has priority over writes.
    always_ff @(posedge clk)
    begin
        if (clearing)
        begin
            mem[clr_reg[AW-1:0]] <= '0;
        end
        else if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_reg <= mem[rd_addr];
        end
    end

    // Neighbour coordinates and grid bounds for the probed face.
    always_comb
    begin
        nx = cmd_reg.x[CW-1:0];
        ny = cmd_reg.y[CW-1:0];
        nz = cmd_reg.z[CW-1:0];
        nb_out = 1'b0;
        nb_solid_out = 1'b1;
        case (f_reg)
            3'd0:
            begin
                nb_out = nx == '0;
                nx = nx - 1'b1;
            end
            3'd1:
            begin
                nb_out = 32'(nx) == SIDE - 1;
                nx = nx + 1'b1;
            end
            3'd2:
            begin
                nb_out = ny == '0;
                ny = ny - 1'b1;
            end
            3'd3:
            begin
                nb_out = 32'(ny) == SIDE - 1;
                nb_solid_out = 1'b0;
                ny = ny + 1'b1;
            end
            3'd4:
            begin
                nb_out = nz == '0;
                nz = nz - 1'b1;
            end
            default:
            begin
                nb_out = 32'(nz) == SIDE - 1;
                nz = nz + 1'b1;
            end
        endcase
    end

    // Next visible face after the current one.
    always_comb
    begin
        rem_mask = vis_reg & ~(6'b1 << f_reg);
        nf = 3'd0;
        has_next = 1'b0;
        for (int i = 5; i >= 0; i--)
        begin
            if (rem_mask[i] && (3'(i) > f_reg))
            begin
                nf = 3'(i);
                has_next = 1'b1;
            end
        end
    end

    assign co = corner_off(face_corner(f_reg, v_reg));

    // Sequencer: centre read, then for a non-empty voxel six probes and vertex emission.
    always_comb
    begin
        st_next = st_reg;
        cmd_next = cmd_reg;
        col_next = col_reg;
        f_next = f_reg;
        v_next = v_reg;
        vis_next = vis_reg;
        ov_next = ov_reg;
        od_next = od_reg;
        clr_next = clearing ? clr_reg + 1'b1 : clr_reg;
        q_pop = 1'b0;
        rd_en = 1'b0;
        rd_addr = {cmd_reg.x[CW-1:0], cmd_reg.y[CW-1:0], cmd_reg.z[CW-1:0]};
        if (ov_reg && !out_stall)
        begin
            ov_next = 1'b0;
        end
        case (st_reg)
            ST_IDLE:
            begin
                if (q_valid && !clearing)
                begin
                    q_pop = 1'b1;
                    cmd_next = q_head;
                    rd_en = 1'b1;
                    rd_addr = {q_head.x[CW-1:0], q_head.y[CW-1:0], q_head.z[CW-1:0]};
                    st_next = ST_CENTRE;
                end
            end
            ST_CENTRE:
            begin
                col_next = rd_reg;
                f_next = 3'd0;
                vis_next = '0;
                st_next = (rd_reg == '0) ? ST_IDLE : ST_PROBE;
            end
            ST_PROBE:
            begin
                rd_en = 1'b1;
                rd_addr = {nx, ny, nz};
                st_next = nb_out ? ST_PROBE : ST_DECIDE;
                if (nb_out)
                begin
                    vis_next[f_reg] = !nb_solid_out;
                    if (f_reg == 3'd5)
                    begin
                        st_next = ST_EMIT;
                        f_next = 3'd0;
                    end
                    else
                    begin
                        f_next = f_reg + 1'b1;
                    end
                end
            end
            ST_DECIDE:
            begin
                vis_next[f_reg] = rd_reg == '0;
                st_next = ST_PROBE;
                if (f_reg == 3'd5)
                begin
                    st_next = ST_EMIT;
                    f_next = 3'd0;
                end
                else
                begin
                    f_next = f_reg + 1'b1;
                end
            end
            ST_EMIT:
            begin
                if (vis_reg == '0)
                begin
                    st_next = ST_IDLE;
                end
                else if (!vis_reg[f_reg])
                begin
                    f_next = f_reg + 1'b1;
                    if (f_reg == 3'd5)
                    begin
                        f_next = 3'd0;
                    end
                    v_next = 3'd0;
                end
                else if (!ov_reg || !out_stall)
                begin
                    ov_next = 1'b1;
                    od_next.vertex_x = 6'(cmd_reg.x) + 6'(co[2]);
                    od_next.vertex_y = 6'(cmd_reg.y) + 6'(co[1]);
                    od_next.vertex_z = 6'(cmd_reg.z) + 6'(co[0]);
                    od_next.vertex_color = col_reg;
                    od_next.face_id = f_reg;
                    od_next.last = (v_reg == 3'd5) && !has_next;
                    if (v_reg == 3'd5)
                    begin
                        v_next = 3'd0;
                        if (has_next)
                        begin
                            f_next = nf;
                        end
                        else
                        begin
                            st_next = ST_IDLE;
                        end
                    end
                    else
                    begin
                        v_next = v_reg + 1'b1;
                    end
                end
            end
            default: st_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= ST_IDLE;
            clr_reg <= '0;
            ov_reg <= 1'b0;
            f_reg <= 3'd0;
            v_reg <= 3'd0;
            vis_reg <= '0;
        end
        else
        begin
            st_reg <= st_next;
            clr_reg <= clr_next;
            ov_reg <= ov_next;
            f_reg <= f_next;
            v_reg <= v_next;
            vis_reg <= vis_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        col_reg <= col_next;
        od_reg <= od_next;
    end

    assign busy = (st_reg != ST_IDLE) || clearing;
    assign out_valid = ov_reg;
    assign out_data = od_reg;

    // Checks on the sequencer.
    `VFCM_ASSERT_IMPL(a_no_pop_clear, clearing, !q_pop)
    `VFCM_ASSERT_IMPL(a_emit_nonzero, ov_reg && !$past(ov_reg), od_reg.vertex_color != '0)
    `VFCM_ASSERT_IMPL(a_face_range, ov_reg, od_reg.face_id <= 3'd5)
    `VFCM_ASSERT_NEXT(a_hold, ov_reg && out_stall, ov_reg && $stable(od_reg))

endmodule

### tb/testbench.sv
// ---------------------------------------------------------------------------
// Voxel face culling mesher testbench
// Drives write and mesh words into the mesher, predicts the vertices of every
// exposed face from a private copy of the voxel grid, and checks each vertex
// word in order under varied sender gaps and receiver stalls.
// ---------------------------------------------------------------------------
module testbench;

    import vfcm_pkg::*;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    in_word_t  in_data;
    logic      out_valid;
    logic      out_stall;
    out_word_t out_data;

    // Private copy of the grid and the queue of vertices still to arrive.
    logic [23:0] grid_colour [0:DEPTH-1];
    out_word_t   vertex_queue [$];
    int          fail_count;
    int          send_gap_pct;
    int          stall_pct;
    bit          hold_off;

    voxel_face_cull_mesher uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
    );

    // Clock.
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic int grid_index(int x, int y, int z);
        return (x * SIDE + y) * SIDE + z;
    endfunction

    // A neighbour is solid if it holds a colour, or lies outside the grid other
    // than above the top.
    function automatic bit neighbour_solid(int x, int y, int z);
        if (x < 0 || x >= SIDE || y < 0 || y >= SIDE || z < 0 || z >= SIDE)
            return y < SIDE;
        return grid_colour[grid_index(x, y, z)] != 24'd0;
    endfunction

    // Update the grid copy and queue the vertices that a word should produce.
    task automatic predict_vertices(in_word_t w);
        logic [2:0] offs [0:7];
        int         quads [0:5][0:3];
        int         dirs [0:5][0:2];
        int         tri_pos [0:5];
        logic [23:0] colour;
        out_word_t  v;
        int         first_new;
        int         c;
        offs = '{3'b001, 3'b101, 3'b111, 3'b011, 3'b000, 3'b100, 3'b110, 3'b010};
        quads = '{'{0, 3, 7, 4}, '{1, 5, 6, 2}, '{0, 4, 5, 1},
                  '{3, 2, 6, 7}, '{7, 6, 5, 4}, '{0, 1, 2, 3}};
        dirs = '{'{-1, 0, 0}, '{1, 0, 0}, '{0, -1, 0}, '{0, 1, 0}, '{0, 0, -1}, '{0, 0, 1}};
        tri_pos = '{0, 1, 2, 0, 2, 3};
        if (w.opcode == OP_WRITE)
        begin
            grid_colour[grid_index(w.voxel_x, w.voxel_y, w.voxel_z)] = w.voxel_value;
            return;
        end
        colour = grid_colour[grid_index(w.voxel_x, w.voxel_y, w.voxel_z)];
        if (colour == 24'd0)
            return;
        first_new = vertex_queue.size();
        for (int f = 0; f < 6; f++)
        begin
            if (!neighbour_solid(w.voxel_x + dirs[f][0], w.voxel_y + dirs[f][1],
                                 w.voxel_z + dirs[f][2]))
            begin
                for (int k = 0; k < 6; k++)
                begin
                    c = quads[f][tri_pos[k]];
                    v.vertex_x = {1'b0, w.voxel_x} + offs[c][2];
                    v.vertex_y = {1'b0, w.voxel_y} + offs[c][1];
                    v.vertex_z = {1'b0, w.voxel_z} + offs[c][0];
                    v.vertex_color = colour;
                    v.face_id = 3'(f);
                    v.last = 1'b0;
                    vertex_queue.push_back(v);
                end
            end
        end
        if (vertex_queue.size() > first_new)
            vertex_queue[$].last = 1'b1;
    endtask

    // Offer one word, with a random gap first, and predict on acceptance.
    // Valid stays high after acceptance until a gap or the end of a burst.
    task automatic send_word(logic op, int x, int y, int z, logic [23:0] colour);
        in_word_t w;
        w.opcode = op;
        w.voxel_x = 5'(x);
        w.voxel_y = 5'(y);
        w.voxel_z = 5'(z);
        w.voxel_value = colour;
        while ($urandom_range(99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= w;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_vertices(w);
    endtask

    // Receiver stall pattern, with an optional long hold-off.
    always @(posedge clk)
    begin
        if (hold_off)
            out_stall <= 1'b1;
        else
            out_stall <= ($urandom_range(99) < stall_pct);
    end

    // Check each accepted vertex word against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (vertex_queue.size() == 0)
            begin
                $display("%0t: unexpected vertex, expected none, actual %h", $time, out_data);
                fail_count++;
            end
            else
            begin
                if (out_data !== vertex_queue[0])
                begin
                    $display("%0t: vertex mismatch, expected %h, actual %h",
                             $time, vertex_queue[0], out_data);
                    fail_count++;
                end
                void'(vertex_queue.pop_front());
            end
        end
    end

    // End the burst and wait for every predicted vertex to arrive.
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (vertex_queue.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    // Corners, top faces and both colour extremes, with hidden cases.
    task automatic test_directed();
        send_word(OP_MESH, 0, 0, 0, 24'hFFFFFF);
        send_word(OP_WRITE, 0, 0, 0, 24'hFFFFFF);
        send_word(OP_MESH, 0, 0, 0, 24'd0);
        send_word(OP_WRITE, 31, 31, 31, 24'h000001);
        send_word(OP_MESH, 31, 31, 31, 24'hFFFFFF);
        send_word(OP_WRITE, 15, 10, 20, 24'hFF0000);
        send_word(OP_MESH, 15, 10, 20, 24'd0);
        send_word(OP_WRITE, 14, 10, 20, 24'h00FF00);
        send_word(OP_WRITE, 16, 10, 20, 24'h0000FF);
        send_word(OP_WRITE, 15, 9, 20, 24'h123456);
        send_word(OP_WRITE, 15, 11, 20, 24'hABCDEF);
        send_word(OP_WRITE, 15, 10, 19, 24'h555555);
        send_word(OP_MESH, 15, 10, 20, 24'd0);
        send_word(OP_WRITE, 15, 10, 21, 24'hAAAAAA);
        send_word(OP_MESH, 15, 10, 20, 24'd0);
        send_word(OP_WRITE, 15, 10, 21, 24'd0);
        send_word(OP_MESH, 15, 10, 20, 24'd0);
        send_word(OP_WRITE, 31, 0, 0, 24'h800000);
        send_word(OP_MESH, 31, 0, 0, 24'h7FFFFF);
        send_word(OP_WRITE, 0, 31, 31, 24'h00FF00);
        send_word(OP_MESH, 0, 31, 31, 24'd0);
        wait_drained();
    endtask

    // Random words clustered in small blocks at the grid corners so that neighbours interact,
    // with some words spread across the whole grid.
    task automatic test_random(int count);
        int x, y, z;
        logic [23:0] colour;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(3) == 0)
            begin
                x = $urandom_range(31);
                y = $urandom_range(31);
                z = $urandom_range(31);
            end
            else
            begin
                x = $urandom_range(1) ? $urandom_range(3) : 28 + $urandom_range(3);
                y = $urandom_range(1) ? $urandom_range(3) : 28 + $urandom_range(3);
                z = $urandom_range(1) ? $urandom_range(3) : 28 + $urandom_range(3);
            end
            colour = ($urandom_range(3) == 0) ? 24'd0 : 24'($urandom);
            send_word($urandom_range(1) ? OP_MESH : OP_WRITE, x, y, z, colour);
        end
        wait_drained();
    endtask

    // Hold the receiver off for a long stretch while the sender keeps offering.
    task automatic test_backpressure();
        fork
            begin
                hold_off = 1'b1;
                repeat (400) @(posedge clk);
                hold_off = 1'b0;
            end
            test_random(15);
        join
    endtask

    initial
    begin
        fail_count = 0;
        send_gap_pct = 0;
        stall_pct = 0;
        hold_off = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_stall = 1'b0;
        foreach (grid_colour[i])
            grid_colour[i] = 24'd0;
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(55);
        send_gap_pct = 81;
        test_random(45);
        send_gap_pct = 0;
        stall_pct = 81;
        test_random(45);
        send_gap_pct = 15;
        stall_pct = 15;
        test_random(45);
        send_gap_pct = 0;
        stall_pct = 0;
        test_backpressure();
        repeat (50) @(posedge clk);
        if (fail_count == 0 && vertex_queue.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Run limit, allowing for the clearing pass after reset.
    initial
    begin
        #5000000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

### files.f
+incdir+sv
sv/vfcm_pkg.sv
sv/vfcm_front.sv
sv/vfcm_queue.sv
sv/vfcm_back.sv
sv/voxel_face_cull_mesher.sv
tb/testbench.sv
